// ===== src/ihex_pkg.sv =====
package ihex_pkg;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 8;
  localparam int ERR_W   = 3;

  typedef enum logic [2:0] {
    PH_COLON   = 3'd0,
    PH_COUNT   = 3'd1,
    PH_ADDR    = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_SKIP    = 3'd6
  } phase_t;

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [ERR_W-1:0] ERR_START = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TYPE  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_SUM   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_END   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NONE  = 3'd4;

  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_SEG       = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_LINEAR    = 8'h04;
  localparam logic [7:0] REC_START     = 8'h05;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

endpackage

// ===== src/ihex_in_if.sv =====
interface ihex_in_if;
  logic                       valid;
  logic                       ready;
  logic [ihex_pkg::CHAR_W-1:0] character;
  logic                       end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink (input valid, input character, input end_of_input, output ready);
endinterface

// ===== src/ihex_out_if.sv =====
interface ihex_out_if;
  logic                        valid;
  logic                        ready;
  logic [ihex_pkg::KIND_W-1:0] kind;
  logic [ihex_pkg::ADDR_W-1:0] address;
  logic [ihex_pkg::DATA_W-1:0] data;
  logic [ihex_pkg::ERR_W-1:0]  error_code;

  modport source (output valid, output kind, output address, output data,
                  output error_code, input ready);
  modport sink (input valid, input kind, input address, input data,
                input error_code, output ready);
endinterface

// ===== src/ihex_cfg_if.sv =====
interface ihex_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/intel_hex_record_parser_top.sv =====
// each result goes into the output register from the character held in the input register
// throughput: one character per cycle while the output side does not stall, set by the single-pass
// record state update that sits between the input register and the output register
// a waiting result stalls the input side only once the input register is also full
// reset (rst, synchronous, active high) clears all parser state, reverse_bits and both valids
module intel_hex_record_parser_top (
  input  logic        clk,
  input  logic        rst,
  ihex_in_if.sink     stream,
  ihex_out_if.source  result,
  ihex_cfg_if.sink    cfg
);

  // input register
  logic                        in_valid;
  logic [ihex_pkg::CHAR_W-1:0] in_char;
  logic                        in_eoi;

  // parser state
  ihex_pkg::phase_t phase, phase_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [15:0] record_address, record_address_next;
  logic [31:0] running_address, running_address_next;
  logic [7:0]  sum, sum_next;
  logic [15:0] shift_value, shift_value_next;
  logic        halted, halted_next;
  logic        reverse_bits;

  // output register
  logic                        out_valid;
  logic [ihex_pkg::KIND_W-1:0] out_kind;
  logic [ihex_pkg::ADDR_W-1:0] out_address;
  logic [ihex_pkg::DATA_W-1:0] out_data;
  logic [ihex_pkg::ERR_W-1:0]  out_error_code;

  logic                        res_valid;
  logic [ihex_pkg::KIND_W-1:0] res_kind;
  logic [ihex_pkg::ADDR_W-1:0] res_address;
  logic [ihex_pkg::DATA_W-1:0] res_data;
  logic [ihex_pkg::ERR_W-1:0]  res_error_code;

  logic advance;
  logic out_load;

  logic        hex_ok;
  logic [3:0]  hex_digit;
  logic [15:0] shifted;
  logic [3:0]  dc_inc;
  logic [7:0]  kind_new;
  logic [7:0]  left_new;
  logic [7:0]  byte_new;
  logic [31:0] running_inc;

  assign advance   = in_valid && (!out_valid || result.ready);
  assign out_load  = advance && res_valid;

  assign stream.ready = !in_valid || advance;
  assign cfg.ready    = 1'b1;

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.address    = out_address;
  assign result.data       = out_data;
  assign result.error_code = out_error_code;

  function automatic logic [7:0] flip_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (in_char >= 8'h30 && in_char <= 8'h39) begin
      hex_digit = in_char[3:0];
    end else if ((in_char >= 8'h61 && in_char <= 8'h66) ||
                 (in_char >= 8'h41 && in_char <= 8'h46)) begin
      hex_digit = in_char[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign shifted = {shift_value[11:0], hex_digit};
  assign dc_inc  = digit_count + 4'd1;

  always_comb begin
    phase_next           = phase;
    digit_count_next     = digit_count;
    bytes_left_next      = bytes_left;
    record_kind_next     = record_kind;
    record_address_next  = record_address;
    running_address_next = running_address;
    sum_next             = sum;
    shift_value_next     = shift_value;
    halted_next          = halted;

    res_valid      = 1'b0;
    res_kind       = ihex_pkg::KIND_DATA;
    res_address    = '0;
    res_data       = '0;
    res_error_code = ihex_pkg::ERR_NONE;

    kind_new    = shifted[7:0];
    byte_new    = shifted[7:0];
    left_new    = bytes_left;
    running_inc = running_address;

    if (!halted) begin
      if (in_eoi) begin
        halted_next    = 1'b1;
        res_valid      = 1'b1;
        res_kind       = ihex_pkg::KIND_ERROR;
        res_error_code = ihex_pkg::ERR_END;
      end else if (phase == ihex_pkg::PH_SKIP) begin
        if (in_char == ihex_pkg::CHAR_LF) phase_next = ihex_pkg::PH_COLON;
      end else if (phase == ihex_pkg::PH_COLON) begin
        if (in_char != ihex_pkg::CHAR_COLON) begin
          halted_next    = 1'b1;
          res_valid      = 1'b1;
          res_kind       = ihex_pkg::KIND_ERROR;
          res_error_code = ihex_pkg::ERR_START;
        end else begin
          phase_next       = ihex_pkg::PH_COUNT;
          digit_count_next = '0;
          shift_value_next = '0;
          sum_next         = '0;
        end
      end else if (!hex_ok) begin
        halted_next    = 1'b1;
        res_valid      = 1'b1;
        res_kind       = ihex_pkg::KIND_ERROR;
        res_error_code = ihex_pkg::ERR_START;
      end else begin
        shift_value_next = shifted;
        digit_count_next = dc_inc;
        case (phase)
          ihex_pkg::PH_COUNT: begin
            if (dc_inc >= 4'd2) begin
              bytes_left_next  = shifted[7:0];
              sum_next         = sum + shifted[7:0];
              phase_next       = ihex_pkg::PH_ADDR;
              digit_count_next = '0;
              shift_value_next = '0;
            end
          end
          ihex_pkg::PH_ADDR: begin
            if (dc_inc >= 4'd4) begin
              record_address_next = shifted;
              sum_next            = sum + shifted[15:8] + shifted[7:0];
              phase_next          = ihex_pkg::PH_TYPE;
              digit_count_next    = '0;
              shift_value_next    = '0;
            end
          end
          ihex_pkg::PH_TYPE: begin
            if (dc_inc >= 4'd2) begin
              record_kind_next = kind_new;
              sum_next         = sum + kind_new;
              digit_count_next = '0;
              shift_value_next = '0;
              if (kind_new == ihex_pkg::REC_EOF) begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
                res_kind    = ihex_pkg::KIND_END;
                res_address = running_address;
              end else if (kind_new > ihex_pkg::REC_START) begin
                halted_next    = 1'b1;
                res_valid      = 1'b1;
                res_kind       = ihex_pkg::KIND_ERROR;
                res_error_code = ihex_pkg::ERR_TYPE;
              end else begin
                if (kind_new == ihex_pkg::REC_DATA) begin
                  running_address_next = {running_address[31:16], record_address};
                end
                if (kind_new == ihex_pkg::REC_SEG || kind_new == ihex_pkg::REC_LINEAR) begin
                  left_new = 8'd2;
                end else if (kind_new == ihex_pkg::REC_START) begin
                  left_new = 8'd4;
                end
                bytes_left_next = left_new;
                phase_next = (left_new == 8'd0) ? ihex_pkg::PH_CHECK : ihex_pkg::PH_PAYLOAD;
              end
            end
          end
          ihex_pkg::PH_PAYLOAD: begin
            if (dc_inc >= 4'd2) begin
              sum_next         = sum + byte_new;
              digit_count_next = '0;
              left_new         = bytes_left - 8'd1;
              bytes_left_next  = left_new;
              if (record_kind == ihex_pkg::REC_DATA) begin
                res_valid   = 1'b1;
                res_kind    = ihex_pkg::KIND_DATA;
                res_address = running_address;
                res_data    = reverse_bits ? flip_byte(byte_new) : byte_new;
                running_inc = running_address + 32'd1;
              end
              running_address_next = running_inc;
              if (left_new == 8'd0) begin
                // upper address records take the last two payload bytes
                if (record_kind == ihex_pkg::REC_SEG &&
                    running_inc[31:4] != {12'd0, shifted}) begin
                  running_address_next = {12'd0, shifted, 4'd0} |
                                         {16'd0, running_inc[15:0]};
                end
                if (record_kind == ihex_pkg::REC_LINEAR &&
                    running_inc[31:16] != shifted) begin
                  running_address_next = {shifted, running_inc[15:0]};
                end
                phase_next       = ihex_pkg::PH_CHECK;
                shift_value_next = '0;
              end
            end
          end
          ihex_pkg::PH_CHECK: begin
            if (dc_inc >= 4'd2) begin
              digit_count_next = '0;
              shift_value_next = '0;
              if (shifted[7:0] != (8'd0 - sum)) begin
                halted_next    = 1'b1;
                res_valid      = 1'b1;
                res_kind       = ihex_pkg::KIND_ERROR;
                res_error_code = ihex_pkg::ERR_SUM;
              end else begin
                phase_next = ihex_pkg::PH_SKIP;
              end
            end
          end
          default: begin
            phase_next       = ihex_pkg::PH_COLON;
            digit_count_next = '0;
            shift_value_next = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (stream.valid && stream.ready) begin
      in_char <= stream.character;
      in_eoi  <= stream.end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ihex_pkg::PH_COLON;
      digit_count     <= '0;
      bytes_left      <= '0;
      record_kind     <= '0;
      record_address  <= '0;
      running_address <= '0;
      sum             <= '0;
      shift_value     <= '0;
      halted          <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      digit_count     <= digit_count_next;
      bytes_left      <= bytes_left_next;
      record_kind     <= record_kind_next;
      record_address  <= record_address_next;
      running_address <= running_address_next;
      sum             <= sum_next;
      shift_value     <= shift_value_next;
      halted          <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_bits <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      reverse_bits <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_kind       <= res_kind;
      out_address    <= res_address;
      out_data       <= res_data;
      out_error_code <= res_error_code;
    end
  end

  // an error or end result always leaves the parser halted
  a_halt_after_final: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_kind != ihex_pkg::KIND_DATA) |=> halted)
    else $error("parser not halted after final result");

  // halted lasts until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

  // no result is produced once halted
  a_no_result_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !out_load)
    else $error("result produced while halted");

  // a held character is not lost while the result side stalls
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_char) && $stable(in_eoi)))
    else $error("pending character dropped");

  // data and end results carry no error code
  a_code_none: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != ihex_pkg::KIND_ERROR) |-> out_error_code == ihex_pkg::ERR_NONE)
    else $error("error code on non-error result");

endmodule
